FILE: design/dctpt_pkg.sv
`default_nettype none

package dctpt_pkg;

    localparam int DAY_W    = 16;
    localparam int MS_W     = 27;
    localparam int DATE_W   = 17;   // day_count + 1 reaches 65536
    localparam int YOFF_W   = 8;    // years past the base, up to about 180
    localparam int STAMP_W  = 32;
    localparam int PC_W     = 5;

    localparam int BASE_YEAR = 1980;
    localparam int MAX_YEAR  = 2043;
    localparam logic [5:0] YEAR_SAT = 6'(MAX_YEAR - BASE_YEAR);

    localparam logic [MS_W-1:0] HOUR_MS   = MS_W'(3600 * 1000);
    localparam logic [MS_W-1:0] MINUTE_MS = MS_W'(60 * 1000);
    localparam logic [MS_W-1:0] SECOND_MS = MS_W'(1000);
    localparam logic [MS_W-1:0] QUAD_DAYS = MS_W'(366 + 365 + 365 + 365);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [0:0] {
        SRC_TIME,
        SRC_DATE
    } src_t;

    typedef enum logic [2:0] {
        K_HOUR,
        K_MINUTE,
        K_SECOND,
        K_QUAD,
        K_YEAR,
        K_MONTH
    } ksel_t;

    typedef enum logic [2:0] {
        D_HOUR,
        D_MINUTE,
        D_SECOND,
        D_YEAR,
        D_MONTH
    } dst_t;

    // One control word: subtract (constant << shift; K_QUAD unshifted) from src when it fits,
    // and bump dst by (1 << shift). rpt holds the step while it keeps hitting.
    typedef struct packed {
        src_t        src;
        ksel_t       ksel;
        logic [2:0]  shift;
        dst_t        dst;
        logic        strict;
        logic        rpt;
        logic        last;
    } uop_t;

    function automatic uop_t ucode_word(input logic [PC_W-1:0] pc);
        uop_t w;
        w = '{SRC_TIME, K_HOUR, 3'd0, D_HOUR, 1'b0, 1'b0, 1'b0};
        case (pc) inside
            [5'd0:5'd5]: begin
                w.shift = 3'(5'd5 - pc);
            end
            [5'd6:5'd11]: begin
                w.ksel  = K_MINUTE;
                w.dst   = D_MINUTE;
                w.shift = 3'(5'd11 - pc);
            end
            [5'd12:5'd17]: begin
                w.ksel  = K_SECOND;
                w.dst   = D_SECOND;
                w.shift = 3'(5'd17 - pc);
            end
            5'd18: begin
                w = '{SRC_DATE, K_QUAD, 3'd2, D_YEAR, 1'b1, 1'b1, 1'b0};
            end
            5'd19: begin
                w = '{SRC_DATE, K_YEAR, 3'd0, D_YEAR, 1'b1, 1'b1, 1'b0};
            end
            default: begin
                w = '{SRC_DATE, K_MONTH, 3'd0, D_MONTH, 1'b1, 1'b1, 1'b1};
            end
        endcase
        return w;
    endfunction

    function automatic logic [8:0] year_days(input logic [1:0] yr_low);
        return (yr_low == 2'd0) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_days(input logic leap, input logic [3:0] month);
        logic [4:0] d;
        case (month)
            4'd2:    d = leap ? 5'd29 : 5'd28;
            4'd4:    d = 5'd30;
            4'd6:    d = 5'd30;
            4'd9:    d = 5'd30;
            4'd11:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: design/dctpt_datapath.sv
`default_nettype none

module dctpt_datapath import dctpt_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               load,
    input  wire logic [DAY_W-1:0]   day_count,
    input  wire logic [MS_W-1:0]    ms_of_day,
    input  wire logic               step_en,
    input  wire uop_t               uop,
    output logic                    hit,
    output logic [STAMP_W-1:0]      packed_stamp
);

    logic [MS_W-1:0]   time_reg,   time_next;
    logic [DATE_W-1:0] date_reg,   date_next;
    logic [5:0]        hour_reg,   hour_next;
    logic [5:0]        minute_reg, minute_next;
    logic [5:0]        second_reg, second_next;
    logic [YOFF_W-1:0] yoff_reg,   yoff_next;
    logic [3:0]        month_reg,  month_next;

    logic [MS_W-1:0]   base;
    logic [MS_W-1:0]   kval;
    logic [MS_W-1:0]   opnd;
    logic [MS_W:0]     diff;
    logic              ge;
    logic              gt;
    logic              month_cap;
    logic [YOFF_W-1:0] inc;

    logic [5:0]        year_f;
    logic [4:0]        day_f;
    logic [4:0]        hour_f;
    logic [5:0]        minute_f;
    logic [5:0]        second_f;

    always_comb begin
        case (uop.ksel)
            K_HOUR:   base = HOUR_MS;
            K_MINUTE: base = MINUTE_MS;
            K_SECOND: base = SECOND_MS;
            K_QUAD:   base = QUAD_DAYS;
            K_YEAR:   base = MS_W'(year_days(yoff_reg[1:0]));
            K_MONTH:  base = MS_W'(month_days(yoff_reg[1:0] == 2'd0, month_reg));
            default:  base = QUAD_DAYS;
        endcase
        // a four-year block takes its days once; only the year count moves by four
        kval = (uop.ksel == K_QUAD) ? base : (base << uop.shift);
        opnd = (uop.src == SRC_DATE) ? MS_W'(date_reg) : time_reg;
        diff = {1'b0, opnd} - {1'b0, kval};
        ge   = !diff[MS_W];
        gt   = ge && (diff[MS_W-1:0] != '0);
        // months stop at December whatever is left
        month_cap = (uop.dst == D_MONTH) && (month_reg == 4'd12);
        hit  = (uop.strict ? gt : ge) && !month_cap;
        inc  = YOFF_W'(1) << uop.shift;
    end

    always_comb begin
        time_next   = time_reg;
        date_next   = date_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        yoff_next   = yoff_reg;
        month_next  = month_reg;
        if (load) begin
            time_next   = ms_of_day;
            date_next   = DATE_W'(day_count) + DATE_W'(1);
            hour_next   = '0;
            minute_next = '0;
            second_next = '0;
            yoff_next   = '0;
            month_next  = 4'd1;
        end else if (step_en && hit) begin
            if (uop.src == SRC_DATE) begin
                date_next = diff[DATE_W-1:0];
            end else begin
                time_next = diff[MS_W-1:0];
            end
            case (uop.dst)
                D_HOUR:   hour_next   = hour_reg   + inc[5:0];
                D_MINUTE: minute_next = minute_reg + inc[5:0];
                D_SECOND: second_next = second_reg + inc[5:0];
                D_YEAR:   yoff_next   = yoff_reg   + inc;
                D_MONTH:  month_next  = month_reg  + 4'd1;
                default:  month_next  = month_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        time_reg   <= time_next;
        date_reg   <= date_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        yoff_reg   <= yoff_next;
        month_reg  <= month_next;
    end

    always_comb begin
        year_f   = (yoff_reg > YOFF_W'(YEAR_SAT)) ? YEAR_SAT : yoff_reg[5:0];
        day_f    = (date_reg > DATE_W'(31)) ? 5'd31 : date_reg[4:0];
        hour_f   = (hour_reg > 6'd23) ? 5'd23 : hour_reg[4:0];
        minute_f = (minute_reg > 6'd59) ? 6'd59 : minute_reg;
        second_f = (second_reg > 6'd59) ? 6'd59 : second_reg;
        packed_stamp = {year_f, month_reg, day_f, hour_f, minute_f, second_f};
    end

endmodule

`default_nettype wire

FILE: design/day_count_to_packed_timestamp_core.sv
// Date/time stamp packer.
// Input stream: one item carries a day count since 1 Jan 1980 (0 = that day)
// and the milliseconds since midnight. Result stream: one item per input, a
// 32-bit stamp {year-1980, month, day, hour, minute, second}, each field
// saturated (year 2043, hour 23).
// Work runs from a 21-word microcode table driving a single 27-bit
// compare/subtract unit: 18 steps split the time into hour, minute and
// second by restoring division against 3600000, 60000 and 1000 ms, then
// the date walks four-year blocks (up to 44), years inside the block (up
// to 3) and months (up to 11), at most 57 hits in all, each walk ending
// on one pass that misses. An item runs through the idle accept, the 18
// time steps, the date passes and a done step, so its time in work is set
// by how many passes the subtract unit makes. One item is in work at a
// time; s_tready is high only while the sequencer is idle.
// The result sits in an output register, so the next item is taken while
// the previous result waits; a stalled receiver holds the finished item in
// its done state until the output register frees.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops
// m_tvalid.
`default_nettype none

module day_count_to_packed_timestamp_core import dctpt_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [15:0] day_count, [42:16] ms_of_day, rest zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] packed_stamp
);

    state_t            state_reg, state_next;
    logic [PC_W-1:0]   pc_reg,    pc_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [STAMP_W-1:0] m_tdata_reg, m_tdata_next;

    uop_t              uop;
    logic              hit;
    logic              load;
    logic              step_en;
    logic              out_load;
    logic [STAMP_W-1:0] stamp;

    assign uop  = ucode_word(pc_reg);
    assign load = s_tvalid && s_tready;

    dctpt_datapath u_datapath (
        .aclk         (aclk),
        .load         (load),
        .day_count    (s_tdata[DAY_W-1:0]),
        .ms_of_day    (s_tdata[DAY_W+MS_W-1:DAY_W]),
        .step_en      (step_en),
        .uop          (uop),
        .hit          (hit),
        .packed_stamp (stamp)
    );

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        s_tready   = 1'b0;
        step_en    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_RUN;
                    pc_next    = '0;
                end
            end
            ST_RUN: begin
                step_en = 1'b1;
                // a repeating step holds the counter while it still subtracts
                if (!(hit && uop.rpt)) begin
                    if (uop.last) begin
                        state_next = ST_DONE;
                    end else begin
                        pc_next = pc_reg + PC_W'(1);
                    end
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = stamp;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pc_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

FILE: design/dctpt_checker.sv
`default_nettype none

module dctpt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // result held while the receiver stalls
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    a_fields_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[25:22] != 4'd0) && (m_tdata[25:22] <= 4'd12)
                  && (m_tdata[21:17] != 5'd0) && (m_tdata[16:12] <= 5'd23)
                  && (m_tdata[11:6] <= 6'd59) && (m_tdata[5:0] <= 6'd59))
        else $error("stamp field out of range");

endmodule

bind day_count_to_packed_timestamp_core dctpt_checker u_dctpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: verif/stamp_checker.sv
`default_nettype none

module stamp_checker import dctpt_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,   // [15:0] day_count, [42:16] ms_of_day, rest zero
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // [31:0] packed_stamp
    output int               errors,
    output int               pending,
    output int               checked,
    output int               year_sat_cnt,
    output int               hour_sat_cnt
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MS_PER_SEC   = 1000;
    localparam int unsigned SEC_PER_HOUR = 3600;
    localparam int unsigned DAY_MS       = 86400000;
    localparam int unsigned FIRST_SAT_DAY = 23376;   // 1 Jan 2044
    localparam int unsigned MONTH_LEN [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    logic [STAMP_W-1:0] stamp_q[$];
    logic [STAMP_W-1:0] want;
    logic [DAY_W-1:0]   in_day;
    logic [MS_W-1:0]    in_ms;

    // Calendar walk: whole years from 1980 (leap every fourth), then months.
    function automatic logic [STAMP_W-1:0] stamp_of(input logic [DAY_W-1:0] day,
                                                    input logic [MS_W-1:0] ms);
        int unsigned date, acc, len, yoff, dom, mon, secs, hr, mn, sc;
        logic        leap;
        logic [5:0]  yfield;
        date = int'(day) + 1;
        acc  = 0;
        yoff = 0;
        forever begin
            len = (yoff % 4 == 0) ? 366 : 365;
            if (acc + len >= date) break;
            acc += len;
            yoff++;
        end
        dom  = date - acc;
        leap = (yoff % 4 == 0);
        acc  = 0;
        mon  = 1;
        while (mon < 12) begin
            len = MONTH_LEN[mon] + ((mon == 2 && leap) ? 1 : 0);
            if (acc + len >= dom) break;
            acc += len;
            mon++;
        end
        dom -= acc;
        secs = int'(ms) / MS_PER_SEC;
        hr   = secs / SEC_PER_HOUR;
        mn   = (secs % SEC_PER_HOUR) / 60;
        sc   = secs % 60;
        yfield = (yoff > 63) ? 6'd63 : 6'(yoff);
        if (hr > 23) hr = 23;
        return {yfield, 4'(mon), 5'(dom), 5'(hr), 6'(mn), 6'(sc)};
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            stamp_q.delete();
            errors       = 0;
            pending      = 0;
            checked      = 0;
            year_sat_cnt = 0;
            hour_sat_cnt = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_day = s_tdata[DAY_W-1:0];
                in_ms  = s_tdata[DAY_W+MS_W-1:DAY_W];
                stamp_q.push_back(stamp_of(in_day, in_ms));
                if (int'(in_day) >= FIRST_SAT_DAY) year_sat_cnt++;
                if (int'(in_ms) >= DAY_MS) hour_sat_cnt++;
            end
            if (m_tvalid && m_tready) begin
                if (stamp_q.size() == 0) begin
                    $display("%0t: unexpected stamp, expected none, got %08h", $time, m_tdata);
                    errors++;
                end else begin
                    want = stamp_q.pop_front();
                    checked++;
                    if (m_tdata !== want) begin
                        $display("%0t: packed_stamp mismatch, expected %08h, got %08h",
                                 $time, want, m_tdata);
                        errors++;
                    end
                end
            end
            pending = stamp_q.size();
        end
    end

endmodule

`default_nettype wire

FILE: verif/day_count_to_packed_timestamp_core_test.sv
`default_nettype none

module day_count_to_packed_timestamp_core_test import dctpt_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 1880;
    localparam int QUIET_TAIL = 300;
    localparam int unsigned DAY_MS = 86400000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // [15:0] day_count, [42:16] ms_of_day, rest zero
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [31:0] packed_stamp

    int errors, pending, checked, year_sat_cnt, hour_sat_cnt;
    bit quiet;

    int unsigned day_pick, ms_pick;
    int unsigned year_edges [11] = '{0, 58, 59, 60, 365, 366, 730, 731, 1095, 1096, 1460};
    int unsigned ms_edges [6]    = '{0, 999, 1000, 59999, 60000, 3599999};

    day_count_to_packed_timestamp_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    stamp_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .errors       (errors),
        .pending      (pending),
        .checked      (checked),
        .year_sat_cnt (year_sat_cnt),
        .hour_sat_cnt (hour_sat_cnt)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("day_count_to_packed_timestamp_core_test: done, errors");
        $finish;
    end

    // Called at a rising edge; returns on the taking edge, or after an idle gap.
    // s_tready is stable at the falling edge since it only moves on the rising one.
    task automatic put_item(input logic [DAY_W-1:0] day, input logic [MS_W-1:0] ms);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, ms, day};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // Receiver backpressure in random bursts.
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    initial begin
        quiet    = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, leap day, year ends, 2044 onward, hour overflow
        put_item(16'd0, 27'd0);
        put_item(16'd65535, 27'd134217727);
        put_item(16'd0, 27'd999);
        put_item(16'd0, 27'd1000);
        put_item(16'd59, 27'd86399999);
        put_item(16'd60, 27'd59999);
        put_item(16'd365, 27'd60000);
        put_item(16'd366, 27'd3599999);
        put_item(16'd424, 27'd3600000);
        put_item(16'd425, 27'd43200000);
        put_item(16'd1460, 27'd86400000);
        put_item(16'd1461, 27'd134217727);
        put_item(16'd23375, 27'd45296789);
        put_item(16'd23376, 27'd0);
        put_item(16'd23435, 27'd1);
        put_item(16'd65535, 27'd0);
        put_item(16'd32768, 27'd67108864);
        put_item(16'd21845, 27'd44739242);
        put_item(16'd43690, 27'd89478485);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i >= N_RANDOM - QUIET_TAIL)
                quiet = 1'b1;
            else if (i % 150 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    day_pick = $urandom_range(0, 65535);
                    ms_pick  = $urandom_range(0, 134217727);
                end
                3, 4, 5: begin
                    // near year and leap-day edges, some past 2043
                    day_pick = $urandom_range(0, 44) * 1461 + year_edges[$urandom_range(0, 10)];
                    if (day_pick > 65535) day_pick = 65535;
                    ms_pick  = $urandom_range(0, 23) * 3600000 + ms_edges[$urandom_range(0, 5)];
                end
                6, 7, 8: begin
                    day_pick = $urandom_range(0, 65535);
                    ms_pick  = $urandom_range(DAY_MS, 134217727);
                end
                default: begin
                    day_pick = $urandom_range(0, 23375);
                    ms_pick  = $urandom_range(0, DAY_MS - 1);
                end
            endcase
            put_item(DAY_W'(day_pick), MS_W'(ms_pick));
        end
        s_tvalid <= 1'b0;

        do @(negedge aclk); while (pending != 0);
        repeat (100) @(posedge aclk);

        $display("checked %0d stamps: %0d dates past 2043, %0d times past midnight",
                 checked, year_sat_cnt, hour_sat_cnt);
        if (errors == 0 && pending == 0)
            $display("day_count_to_packed_timestamp_core_test: done, clean");
        else
            $display("day_count_to_packed_timestamp_core_test: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
